[rtl/bdpc_pkg.sv]
// Shared types, constants and register codes for the button debounce press classifier.
package bdpc_pkg;

	localparam int NUM_BUTTONS_DEF = 4;
	localparam int IO_BUTTONS      = 4;
	localparam int CFG_INDEX_W     = 2;
	localparam int CFG_DATA_W      = 16;

	// register indexes on the configuration port
	localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_ENABLE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_COUNT  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PRESS_MS   = 2'd2;

	// register reset values
	localparam logic [7:0]  DEBOUNCE_COUNT_RST = 8'd10;
	localparam logic [15:0] LONG_PRESS_MS_RST  = 16'd1500;

	localparam logic [7:0] CNT_MAX = 8'hFF;

	// per-button result codes
	localparam logic [1:0] CODE_NONE  = 2'd0;
	localparam logic [1:0] CODE_SHORT = 2'd1;
	localparam logic [1:0] CODE_LONG  = 2'd2;

	typedef struct packed {
		logic [3:0]  raw_levels;
		logic [31:0] now_ms;
	} in_word_t;

	typedef struct packed {
		logic       report_valid;
		logic [1:0] code_b0;
		logic [1:0] code_b1;
		logic [1:0] code_b2;
		logic [1:0] code_b3;
		logic [3:0] pressed_now;
	} out_word_t;

	typedef struct packed {
		logic        debounce_enable;
		logic [7:0]  debounce_count;
		logic [15:0] long_press_ms;
	} cfg_t;

	// per-button status toward the top level; values after this poll, before report
	typedef struct packed {
		logic pressed;
		logic fire;
		logic long_armed;
		logic short_armed;
		logic fire_held;   // stored fire flag from the previous poll
	} btn_status_t;

endpackage

[rtl/bdpc_button.sv]
// One button: debounce counter, pressed state, change time and long/short press arming.
module bdpc_button
	import bdpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        pressed_in,
	input  logic [31:0] now_ms,
	input  logic        advance,
	input  logic        any_fire,
	output btn_status_t status,
	output logic [1:0]  code
);

	logic        st_q, sa_q, la_q, hb_q, ff_q;
	logic [7:0]  cnt_q;
	logic [31:0] time_q;

	logic        agree, flip;
	logic [7:0]  cnt1, cnt2;
	logic        st2;
	logic [31:0] t2;
	logic [31:0] held;
	logic        sa_n, la_n, hb_n, ff_n;

	// debounce
	always_comb begin
		agree = (pressed_in == st_q);
		cnt1  = cnt_q;
		cnt2  = cnt_q;
		flip  = 1'b0;
		if (cfg.debounce_enable) begin
			if (agree) begin
				cnt1 = (cnt_q != 8'd0) ? cnt_q - 8'd1 : cnt_q;
			end else begin
				cnt1 = (cnt_q != CNT_MAX) ? cnt_q + 8'd1 : cnt_q;
			end
			flip = (cnt1 >= cfg.debounce_count);
			cnt2 = flip ? 8'd0 : cnt1;
		end else begin
			flip = !agree;
		end
		st2 = flip ? !st_q : st_q;
		t2  = flip ? now_ms : time_q;
	end

	// classify
	always_comb begin
		held = now_ms - t2;
		sa_n = sa_q;
		la_n = la_q;
		hb_n = hb_q;
		ff_n = ff_q;
		if (st2 && !hb_q) begin
			if (held > {16'd0, cfg.long_press_ms}) begin
				if (!la_q) begin
					la_n = 1'b1;
					sa_n = 1'b0;
				end else begin
					ff_n = 1'b1;
					hb_n = 1'b1;
				end
			end else begin
				sa_n = 1'b1;
			end
		end else if (!st2) begin
			if (sa_q) begin
				ff_n = 1'b1;
			end
			hb_n = 1'b0;
		end
	end

	always_comb begin
		status.pressed     = st2;
		status.fire        = ff_n;
		status.long_armed  = la_n;
		status.short_armed = sa_n;
		status.fire_held   = ff_q;
		code = CODE_NONE;
		if (any_fire) begin
			if (la_n) begin
				code = CODE_LONG;
			end else if (sa_n) begin
				code = CODE_SHORT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= 1'b0;
			cnt_q  <= 8'd0;
			time_q <= 32'd0;
			sa_q   <= 1'b0;
			la_q   <= 1'b0;
			hb_q   <= 1'b0;
			ff_q   <= 1'b0;
		end else if (advance) begin
			st_q   <= st2;
			cnt_q  <= cnt2;
			time_q <= t2;
			hb_q   <= hb_n;
			la_q   <= la_n && !any_fire;
			sa_q   <= sa_n && !(any_fire && !la_n);
			ff_q   <= ff_n && !(any_fire && (la_n || sa_n));
		end
	end

endmodule

[rtl/button_debounce_press_classifier.sv]
// Top level of the button debounce press classifier: handshakes, registers, report assembly.
//
// Usage: each word on the input channel (in_valid/in_ready/in_data) is one poll:
// four active-low pin levels and the current millisecond time. Every poll yields
// exactly one word on the output channel (out_valid/out_ready/out_data) with the
// report flag, one code per button (none, short, long) and the debounced states.
// Pipeline: an input register (stage 1) feeds the per-button debounce and classify
// logic, whose result lands in the output register. out_valid rises when the
// stage 1 word moves into the output register; throughput is one poll per cycle
// while the receiver takes each word, set by the single per-button update of the
// stage 1 word (one subtract and compare on the time).
// A stalled receiver holds the output word; stage 1 still takes one more poll,
// then in_ready drops until the output word is taken.
// Configuration: cfg_we writes cfg_wdata into the register named by cfg_index
// (0 debounce enable, 1 debounce count, 2 long press ms); write only while idle.
// Reset (arst_n low): pipeline empty, all button state cleared, registers to
// debounce off, count 10, long press 1500 ms.
module button_debounce_press_classifier
	import bdpc_pkg::*;
#(
	parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  in_word_t               in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output out_word_t              out_data
);

	cfg_t      cfg_q;
	logic      valid_s1;
	in_word_t  data_s1;
	logic      out_valid_q;
	out_word_t out_data_q;
	logic      advance;

	btn_status_t status [NUM_BUTTONS];
	logic [1:0]  codes  [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0] fire_vec, fire_held_vec;
	logic        any_fire;
	logic [1:0]  code_io    [IO_BUTTONS];
	logic        pressed_io [IO_BUTTONS];
	out_word_t   result;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_enable <= 1'b0;
			cfg_q.debounce_count  <= DEBOUNCE_COUNT_RST;
			cfg_q.long_press_ms   <= LONG_PRESS_MS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DEBOUNCE_ENABLE: cfg_q.debounce_enable <= cfg_wdata[0];
				CFG_DEBOUNCE_COUNT:  cfg_q.debounce_count  <= cfg_wdata[7:0];
				CFG_LONG_PRESS_MS:   cfg_q.long_press_ms   <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// handshake: stage 1 moves into the output register when that register is empty or its word is taken
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
	end

	// per-button logic; buttons beyond the pins always read released
	genvar b;
	generate
		for (b = 0; b < NUM_BUTTONS; b++) begin : g_btn
			logic pressed_pin;
			if (b < IO_BUTTONS) begin : g_pin
				assign pressed_pin = !data_s1.raw_levels[b];
			end else begin : g_nopin
				assign pressed_pin = 1'b0;
			end
			bdpc_button u_button (
				.clk        (clk),
				.arst_n     (arst_n),
				.cfg        (cfg_q),
				.pressed_in (pressed_pin),
				.now_ms     (data_s1.now_ms),
				.advance    (advance),
				.any_fire   (any_fire),
				.status     (status[b]),
				.code       (codes[b])
			);
			assign fire_vec[b]      = status[b].fire;
			assign fire_held_vec[b] = status[b].fire_held;
		end
		for (b = 0; b < IO_BUTTONS; b++) begin : g_io
			if (b < NUM_BUTTONS) begin : g_live
				assign code_io[b]    = codes[b];
				assign pressed_io[b] = status[b].pressed;
			end else begin : g_absent
				assign code_io[b]    = CODE_NONE;
				assign pressed_io[b] = 1'b0;
			end
		end
	endgenerate

	assign any_fire = |fire_vec;

	always_comb begin
		result.report_valid = any_fire;
		result.code_b0      = code_io[0];
		result.code_b1      = code_io[1];
		result.code_b2      = code_io[2];
		result.code_b3      = code_io[3];
		result.pressed_now  = {pressed_io[3], pressed_io[2], pressed_io[1], pressed_io[0]};
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef NO_ASSERTIONS
	// a report always clears every fire flag, so none survives a poll
	a_fire_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		fire_held_vec == '0)
		else $error("fire flag left set after a poll");

	// without a report every code is none
	a_quiet_codes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.report_valid |->
		out_data.code_b0 == CODE_NONE && out_data.code_b1 == CODE_NONE &&
		out_data.code_b2 == CODE_NONE && out_data.code_b3 == CODE_NONE)
		else $error("code set without report");

	// full pipeline with a stalled receiver must stop taking words
	a_stall_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid && !out_ready |-> !in_ready)
		else $error("input accepted while pipeline full");

	// an advancing stage 1 word always lands in the output register as a valid word
	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("advanced word missing from output register");
`endif

endmodule
